[rtl/wsdf_pkg.sv]
`default_nettype none

package wsdf_pkg;

    // Parser phases
    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_MASK = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;
    localparam logic [3:0] MASK_BYTES    = 4'd4;

    localparam logic [31:0] LIMIT_RESET = 32'd67108864;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic       final_flag;
        logic       frame_end;
    } result_t;

endpackage

`default_nettype wire

[rtl/wsdf_parser.sv]
`default_nettype none

module wsdf_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [31:0]      cfg_data,
    input  wire logic             byte_take,
    input  wire logic [7:0]       rx_byte,
    output logic                  res_valid,
    output wsdf_pkg::result_t     res
);

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    logic [63:0] remaining_len_reg, remaining_len_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  mask_pos_reg, mask_pos_next;
    logic [3:0]  cur_opcode_reg, cur_opcode_next;
    logic        cur_fin_reg, cur_fin_next;
    logic        cur_masked_reg, cur_masked_next;
    logic        halted_reg, halted_next;
    logic [31:0] limit_reg;

    logic        hdr_done;
    logic [7:0]  key_byte;

    always_comb
    begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        remaining_len_next = remaining_len_reg;
        mask_key_next      = mask_key_reg;
        mask_pos_next      = mask_pos_reg;
        cur_opcode_next    = cur_opcode_reg;
        cur_fin_next       = cur_fin_reg;
        cur_masked_next    = cur_masked_reg;
        halted_next        = halted_reg;
        hdr_done           = 1'b0;
        res_valid          = 1'b0;
        res.kind           = wsdf_pkg::KIND_DATA;
        res.data_byte      = 8'd0;
        res.frame_opcode   = cur_opcode_reg;
        res.final_flag     = cur_fin_reg;
        res.frame_end      = 1'b0;

        case (mask_pos_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase

        if (byte_take && !halted_reg)
        begin
            case (phase_reg)
                wsdf_pkg::PH_HDR1:
                begin
                    cur_masked_next = rx_byte[7];
                    mask_key_next   = 32'd0;
                    if (rx_byte[6:0] <= wsdf_pkg::LEN_MAX_SHORT)
                    begin
                        remaining_len_next = {57'd0, rx_byte[6:0]};
                        if (rx_byte[7])
                        begin
                            phase_next      = wsdf_pkg::PH_MASK;
                            byte_count_next = 4'd0;
                        end
                        else
                        begin
                            hdr_done = 1'b1;
                        end
                    end
                    else
                    begin
                        remaining_len_next = 64'd0;
                        byte_count_next    = (rx_byte[6:0] == wsdf_pkg::LEN_EXT16) ?
                                             wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
                        phase_next         = wsdf_pkg::PH_EXT;
                    end
                end
                wsdf_pkg::PH_EXT:
                begin
                    remaining_len_next = {remaining_len_reg[55:0], rx_byte};
                    byte_count_next    = byte_count_reg - 4'd1;
                    if (byte_count_next == 4'd0)
                    begin
                        if (cur_masked_reg)
                        begin
                            phase_next      = wsdf_pkg::PH_MASK;
                            byte_count_next = 4'd0;
                        end
                        else
                        begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                wsdf_pkg::PH_MASK:
                begin
                    mask_key_next   = {mask_key_reg[23:0], rx_byte};
                    byte_count_next = byte_count_reg + 4'd1;
                    if (byte_count_next >= wsdf_pkg::MASK_BYTES)
                    begin
                        hdr_done = 1'b1;
                    end
                end
                wsdf_pkg::PH_DATA:
                begin
                    mask_pos_next      = mask_pos_reg + 2'd1;
                    remaining_len_next = remaining_len_reg - 64'd1;
                    res_valid          = 1'b1;
                    res.data_byte      = rx_byte ^ key_byte;
                    if (remaining_len_reg == 64'd1)
                    begin
                        phase_next    = wsdf_pkg::PH_HDR0;
                        res.frame_end = 1'b1;
                    end
                end
                default:
                begin
                    cur_fin_next    = rx_byte[7];
                    cur_opcode_next = rx_byte[3:0];
                    phase_next      = wsdf_pkg::PH_HDR1;
                end
            endcase

            // Header complete: empty frame, oversize, or enter payload
            if (hdr_done)
            begin
                if (remaining_len_next == 64'd0)
                begin
                    phase_next    = wsdf_pkg::PH_HDR0;
                    res_valid     = 1'b1;
                    res.kind      = wsdf_pkg::KIND_EMPTY;
                    res.frame_end = 1'b1;
                end
                else if (remaining_len_next > {32'd0, limit_reg})
                begin
                    halted_next   = 1'b1;
                    phase_next    = wsdf_pkg::PH_HDR0;
                    res_valid     = 1'b1;
                    res.kind      = wsdf_pkg::KIND_ERROR;
                    res.frame_end = 1'b1;
                end
                else
                begin
                    phase_next    = wsdf_pkg::PH_DATA;
                    mask_pos_next = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= wsdf_pkg::PH_HDR0;
            byte_count_reg    <= 4'd0;
            remaining_len_reg <= 64'd0;
            mask_key_reg      <= 32'd0;
            mask_pos_reg      <= 2'd0;
            cur_opcode_reg    <= 4'd0;
            cur_fin_reg       <= 1'b0;
            cur_masked_reg    <= 1'b0;
            halted_reg        <= 1'b0;
            limit_reg         <= wsdf_pkg::LIMIT_RESET;
        end
        else
        begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            remaining_len_reg <= remaining_len_next;
            mask_key_reg      <= mask_key_next;
            mask_pos_reg      <= mask_pos_next;
            cur_opcode_reg    <= cur_opcode_next;
            cur_fin_reg       <= cur_fin_next;
            cur_masked_reg    <= cur_masked_next;
            halted_reg        <= halted_next;
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/wsdf_out_reg.sv]
`default_nettype none

module wsdf_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire wsdf_pkg::result_t load_data,
    input  wire logic              take,
    output logic                   full,
    output wsdf_pkg::result_t      held
);

    logic              full_reg;
    wsdf_pkg::result_t held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (load)
        begin
            full_reg <= 1'b1;
        end
        else if (take)
        begin
            full_reg <= 1'b0;
        end
    end

    // Payload holds until the next load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= load_data;
        end
    end

    assign full = full_reg;
    assign held = held_reg;

endmodule

`default_nettype wire

[rtl/websocket_frame_deframer.sv]
`default_nettype none

// WebSocket receive deframer: takes the framed byte stream one byte per transfer
// on rx_byte and returns, for every payload byte, the unmasked byte with the
// frame's opcode and fin bit, frame_end marking the frame's last byte. Header,
// extended length and mask key bytes give no result; a zero-length frame gives
// one empty-frame notice (kind 1), and a frame longer than max_payload_len
// (written on the cfg port, 67108864 after reset) gives one error (kind 2)
// after which every byte is dropped until reset. The parser updates its state
// in the cycle of the transfer and its result appears in the output register
// on the next cycle; the sustained rate is one byte per cycle while the output
// register is not stalled. in_ready drops only while that output register
// holds a result and out_ready is low.
module websocket_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [3:0]       frame_opcode,
    output logic             final_flag,
    output logic             frame_end
);

    logic              in_take;
    logic              res_valid;
    wsdf_pkg::result_t res;
    logic              out_full;
    wsdf_pkg::result_t out_res;

    // Config writes are always taken; the user must make them only while the block is idle (not enforced here)
    assign cfg_ready = 1'b1;

    // Accept a new byte whenever the output register is free or draining
    assign in_ready = !out_full || out_ready;
    assign in_take  = in_valid && in_ready;

    wsdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_data  (cfg_data),
        .byte_take (in_take),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold each result until the downstream transfer completes
    wsdf_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .take      (out_ready),
        .full      (out_full),
        .held      (out_res)
    );

    assign out_valid    = out_full;
    assign kind         = out_res.kind;
    assign data_byte    = out_res.data_byte;
    assign frame_opcode = out_res.frame_opcode;
    assign final_flag   = out_res.final_flag;
    assign frame_end    = out_res.frame_end;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int MAX_REPORTS    = 10;

    // Length encodings of the second header byte
    localparam int ENC_SHORT = 0;
    localparam int ENC_EXT16 = 1;
    localparam int ENC_EXT64 = 2;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Opening frames, one per header form:
    //   zero-length frame with fin set and opcode 0xF,
    //   masked 5-byte frame (key index wraps past byte 3),
    //   16-bit extended length of 2 with payload extremes,
    //   64-bit extended length of 1.
    localparam logic [7:0] OPENING [30] = '{
        8'h8F, 8'h00,
        8'h01, 8'h85, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h12,
        8'h82, 8'h7E, 8'h00, 8'h02, 8'h00, 8'hFF,
        8'h09, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hC3
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [3:0]  frame_opcode;
    logic        final_flag;
    logic        frame_end;

    websocket_frame_deframer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_opcode (frame_opcode),
        .final_flag   (final_flag),
        .frame_end    (frame_end)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Byte stream waiting to be sent, and results the deframer still owes
    logic [7:0]          rx_stream [$];
    wsdf_pkg::result_t   frame_results_due [$];

    int queued_cnt   = 0;
    int accepted_cnt = 0;
    int limit_writes = 0;
    int errors       = 0;
    int kind_cnt [3] = '{0, 0, 0};

    // Shadow of the deframer state, updated on every input transfer
    logic [2:0]  ps_phase     = wsdf_pkg::PH_HDR0;
    logic [3:0]  ps_hdr_left  = 4'd0;
    logic [63:0] ps_bytes_due = 64'd0;
    logic [31:0] ps_key       = 32'd0;
    logic [1:0]  ps_key_idx   = 2'd0;
    logic [3:0]  ps_opcode    = 4'd0;
    logic        ps_fin       = 1'b0;
    logic        ps_masked    = 1'b0;
    logic        ps_halted    = 1'b0;
    logic [31:0] ps_limit     = wsdf_pkg::LIMIT_RESET;

    task automatic owe_result(input logic [1:0] k, input logic [7:0] d, input logic last);
        wsdf_pkg::result_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.frame_opcode = ps_opcode;
        r.final_flag   = ps_fin;
        r.frame_end    = last;
        frame_results_due = {frame_results_due, r};
    endtask

    // Header fully parsed: empty notice, oversize error (halt), or start payload
    task automatic header_complete();
        if (ps_bytes_due == 64'd0) begin
            ps_phase = wsdf_pkg::PH_HDR0;
            owe_result(wsdf_pkg::KIND_EMPTY, 8'd0, 1'b1);
        end
        else if (ps_bytes_due > {32'd0, ps_limit}) begin
            ps_halted = 1'b1;
            ps_phase  = wsdf_pkg::PH_HDR0;
            owe_result(wsdf_pkg::KIND_ERROR, 8'd0, 1'b1);
        end
        else begin
            ps_phase   = wsdf_pkg::PH_DATA;
            ps_key_idx = 2'd0;
        end
    endtask

    task automatic length_complete();
        if (ps_masked) begin
            ps_phase    = wsdf_pkg::PH_MASK;
            ps_hdr_left = 4'd0;
        end
        else begin
            header_complete();
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] key_byte;
        if (ps_halted)
            return;
        case (ps_phase)
            wsdf_pkg::PH_HDR1: begin
                ps_masked = b[7];
                ps_key    = 32'd0;
                if (b[6:0] <= wsdf_pkg::LEN_MAX_SHORT) begin
                    ps_bytes_due = {57'd0, b[6:0]};
                    length_complete();
                end
                else begin
                    ps_bytes_due = 64'd0;
                    ps_hdr_left  = (b[6:0] == wsdf_pkg::LEN_EXT16) ?
                                   wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
                    ps_phase     = wsdf_pkg::PH_EXT;
                end
            end
            wsdf_pkg::PH_EXT: begin
                ps_bytes_due = {ps_bytes_due[55:0], b};
                ps_hdr_left  = ps_hdr_left - 4'd1;
                if (ps_hdr_left == 4'd0)
                    length_complete();
            end
            wsdf_pkg::PH_MASK: begin
                ps_key      = {ps_key[23:0], b};
                ps_hdr_left = ps_hdr_left + 4'd1;
                if (ps_hdr_left >= wsdf_pkg::MASK_BYTES)
                    header_complete();
            end
            wsdf_pkg::PH_DATA: begin
                // first key byte sits in the top 8 bits
                key_byte     = ps_key[8 * (3 - ps_key_idx) +: 8];
                ps_key_idx   = ps_key_idx + 2'd1;
                ps_bytes_due = ps_bytes_due - 64'd1;
                if (ps_bytes_due == 64'd0) begin
                    ps_phase = wsdf_pkg::PH_HDR0;
                    owe_result(wsdf_pkg::KIND_DATA, b ^ key_byte, 1'b1);
                end
                else begin
                    owe_result(wsdf_pkg::KIND_DATA, b ^ key_byte, 1'b0);
                end
            end
            default: begin
                ps_fin    = b[7];
                ps_opcode = b[3:0];
                ps_phase  = wsdf_pkg::PH_HDR1;
            end
        endcase
    endtask

    // Stream builders
    task automatic queue_byte(input logic [7:0] b);
        rx_stream = {rx_stream, b};
        queued_cnt++;
    endtask

    task automatic queue_header(input logic [63:0] len, input int enc, input logic with_key);
        queue_byte(8'($urandom));
        case (enc)
            ENC_SHORT: queue_byte({with_key, len[6:0]});
            ENC_EXT16: begin
                queue_byte({with_key, wsdf_pkg::LEN_EXT16});
                queue_byte(len[15:8]);
                queue_byte(len[7:0]);
            end
            default: begin
                queue_byte({with_key, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    queue_byte(len[8 * i +: 8]);
            end
        endcase
        if (with_key)
            repeat (4) queue_byte(8'($urandom));
    endtask

    task automatic queue_body(input int n);
        repeat (n) queue_byte(8'($urandom));
    endtask

    function automatic int pick_enc(input int len);
        int sel;
        sel = $urandom_range(0, 9);
        if (len > 125)
            return (sel < 6) ? ENC_EXT16 : ENC_EXT64;
        if (sel < 7)
            return ENC_SHORT;
        return (sel < 9) ? ENC_EXT16 : ENC_EXT64;
    endfunction

    // Mostly short frames, some medium and long, a few right at the cap
    function automatic int pick_len(input int cap);
        int sel;
        int len;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            len = 0;
        else if (sel < 12)
            len = $urandom_range(1, 16);
        else if (sel < 17)
            len = $urandom_range(17, 125);
        else if (sel < 19)
            len = $urandom_range(126, 300);
        else
            len = cap;
        if (len > cap)
            len = $urandom_range(0, cap);
        return len;
    endfunction

    task automatic random_frame(input int cap);
        int len;
        len = pick_len(cap);
        queue_header(64'(len), pick_enc(len), 1'($urandom_range(0, 1)));
        queue_body(len);
    endtask

    // Hold until every queued byte has transferred and every result has come back,
    // then let the output register settle before touching the limit.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (accepted_cnt != queued_cnt || frame_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_limit(input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Transfer tracker: advance the shadow state on each input transfer and
    // pick up limit writes on each config transfer.
    logic in_taken = 1'b0;

    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            deframe_byte(rx_byte);
            accepted_cnt++;
        end
        if (rst_n && cfg_valid && cfg_ready) begin
            ps_limit = cfg_data;
            limit_writes++;
        end
    end

    // Sender: bursts of random length separated by random gaps, occasionally
    // a long gap and sometimes none, so idle cycles land in every parse phase.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_taken) begin
            // hold byte until it transfers
        end
        else if (gap_left != 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (rx_stream.size() != 0) begin
            in_valid <= 1'b1;
            rx_byte  <= rx_stream.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 32);
                case ($urandom_range(0, 3))
                    0: gap_left <= 0;
                    1: gap_left <= $urandom_range(10, 20);
                    default: gap_left <= $urandom_range(1, 5);
                endcase
            end
            else begin
                burst_left <= burst_left - 1;
            end
        end
        else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: alternate ready and stall runs; now and then a long ready run
    int ready_run  = 0;
    int ready_pick = 0;

    always @(negedge clk)
    begin
        if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end
        else begin
            ready_pick = $urandom_range(0, 9);
            if (ready_pick < 3) begin
                out_ready <= 1'b0;
                ready_run <= $urandom_range(0, 9);
            end
            else if (ready_pick == 9) begin
                out_ready <= 1'b1;
                ready_run <= $urandom_range(50, 150);
            end
            else begin
                out_ready <= 1'b1;
                ready_run <= $urandom_range(0, 20);
            end
        end
    end

    // Monitor: compare each output transfer against the oldest owed result
    wsdf_pkg::result_t got;
    wsdf_pkg::result_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            got = '{kind, data_byte, frame_opcode, final_flag, frame_end};
            if (frame_results_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result kind=%0d data=%02h op=%h fin=%b end=%b",
                             $realtime, got.kind, got.data_byte, got.frame_opcode,
                             got.final_flag, got.frame_end);
            end
            else begin
                want = frame_results_due.pop_front();
                if (want.kind <= wsdf_pkg::KIND_ERROR)
                    kind_cnt[want.kind]++;
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t: mismatch expected kind=%0d data=%02h op=%h fin=%b end=%b",
                                  " got kind=%0d data=%02h op=%h fin=%b end=%b"},
                                 $realtime, want.kind, want.data_byte, want.frame_opcode,
                                 want.final_flag, want.frame_end, got.kind, got.data_byte,
                                 got.frame_opcode, got.final_flag, got.frame_end);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int cap;
        int len;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Opening frames under the reset limit
        foreach (OPENING[i])
            queue_byte(OPENING[i]);
        wait_idle();

        // Widest limit, random traffic
        set_limit(32'hFFFF_FFFF);
        while (queued_cnt < 450)
            random_frame(300);
        wait_idle();

        // Small limit: first a frame exactly at the limit, then traffic up to it
        cap = $urandom_range(20, 160);
        set_limit(32'(cap));
        queue_header(64'(cap), ENC_EXT64, 1'b1);
        queue_body(cap);
        while (queued_cnt < 720)
            random_frame(cap);
        wait_idle();

        // Zero limit: empty frames in randomly chosen encodings still pass
        set_limit(32'd0);
        repeat (12)
            queue_header(64'd0, $urandom_range(ENC_SHORT, ENC_EXT64),
                         1'($urandom_range(0, 1)));
        wait_idle();

        // Oversize frame: either a 64-bit length with its top bit set against the
        // widest limit, or any nonzero length against the zero limit. Then drop
        // into halt and feed bytes that must all be ignored.
        if ($urandom_range(0, 1)) begin
            set_limit(32'hFFFF_FFFF);
            queue_header({1'b1, 31'($urandom), 32'($urandom)}, ENC_EXT64, 1'b1);
        end
        else begin
            len = $urandom_range(1, 300);
            queue_header(64'(len), pick_enc(len), 1'($urandom_range(0, 1)));
        end
        queue_byte(8'h81);
        queue_byte(8'h05);
        queue_body(40);

        do
            @(negedge clk);
        while (accepted_cnt != queued_cnt || frame_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (frame_results_due.size() != 0) begin
            errors += frame_results_due.size();
            $display("%0d results never arrived", frame_results_due.size());
        end
        $display("Sent %0d stream bytes across %0d limit settings.", accepted_cnt, limit_writes);
        $display("Checked %0d payload bytes, %0d empty-frame notices, %0d oversize errors.",
                 kind_cnt[wsdf_pkg::KIND_DATA], kind_cnt[wsdf_pkg::KIND_EMPTY],
                 kind_cnt[wsdf_pkg::KIND_ERROR]);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout");
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/wsdf_pkg.sv
rtl/wsdf_parser.sv
rtl/wsdf_out_reg.sv
rtl/websocket_frame_deframer.sv
dv/tb.sv
